// ===== hw/rtl/cdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared types, command and status codes, calendar tables and the
// reciprocal constants used by the shared constant multiplier.
// ----------------------------------------------------------------------------
package cdc_pkg;

   // Command codes on req_cmd. Codes above CMD_QUERY behave as a query.
   localparam logic [2:0] CMD_SET   = 3'd0;
   localparam logic [2:0] CMD_NEXT  = 3'd1;
   localparam logic [2:0] CMD_PREV  = 3'd2;
   localparam logic [2:0] CMD_ADD   = 3'd3;
   localparam logic [2:0] CMD_QUERY = 3'd4;

   // Status codes on rsp_status.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_MONTH = 2'd1;
   localparam logic [1:0] ST_BAD_DAY   = 2'd2;
   localparam logic [1:0] ST_BAD_YEAR  = 2'd3;

   // Reciprocals: x / 100 = (x * 5243) >> 19 for x below 2**14,
   // x / 7 = (x * 37450) >> 18 for x below 2**15.
   localparam logic [15:0] RECIP_100 = 16'd5243;
   localparam logic [15:0] RECIP_7   = 16'd37450;

   typedef enum logic [0:0] {
      MUL_DIV100,
      MUL_DIV7
   } mul_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LQ,
      S_LEAP,
      S_WALK,
      S_WQ,
      S_WSUM,
      S_W7,
      S_WMOD
   } state_type;

   // Length of a month in a common year.
   function automatic logic [4:0] month_days(input logic [3:0] m);
      logic [4:0] d;
      unique case (m)
         4'd2:                      d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

   // Days before the first of a month in a common year.
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] d;
      unique case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Month term of Zeller's congruence, (13 * m + 8) / 5, with January and
   // February counted as months 13 and 14 of the previous year.
   function automatic logic [5:0] zeller_term(input logic [3:0] m);
      logic [5:0] z;
      unique case (m)
         4'd1:    z = 6'd35;
         4'd2:    z = 6'd38;
         4'd3:    z = 6'd9;
         4'd4:    z = 6'd12;
         4'd5:    z = 6'd14;
         4'd6:    z = 6'd17;
         4'd7:    z = 6'd19;
         4'd8:    z = 6'd22;
         4'd9:    z = 6'd25;
         4'd10:   z = 6'd27;
         4'd11:   z = 6'd30;
         default: z = 6'd32;
      endcase
      return z;
   endfunction

endpackage

// ===== hw/rtl/cdc_mul.sv =====
// ----------------------------------------------------------------------------
// Shared constant multiplier
// Multiplies an operand by one of the package reciprocals; the product is
// registered, so it is read in the cycle after the operand is presented.
// ----------------------------------------------------------------------------
module cdc_mul (
   input  logic                clock,
   input  logic [14:0]         op_a,
   input  cdc_pkg::mul_sel_type sel,
   output logic [30:0]         prod
);
   import cdc_pkg::*;

   logic [15:0] recip;
   logic [30:0] prod_ff;
   logic [30:0] prod_in;

   always_comb begin
      unique case (sel)
         MUL_DIV100: recip = RECIP_100;
         MUL_DIV7:   recip = RECIP_7;
         default:    recip = RECIP_100;
      endcase
      prod_in = {16'd0, op_a} * {15'd0, recip};
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/calendar_date_counter.sv =====
// ----------------------------------------------------------------------------
// Calendar date counter
// Holds one Gregorian date and runs one command per word: set, next day,
// previous day, add days or query, answering with date, weekday, day of
// year, leap flag and status.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   request  start high, busy low   req_cmd, req_year, req_month, req_amount
//   result   rsp_strobe, one cycle  rsp_cur_year .. rsp_status
//
// A word moves through a small sequencer. The date walk moves one whole month per cycle,
// but a valid set, and each change of year, passes through S_LQ and S_LEAP while the shared
// multiplier finds the leap flag. The weekday takes four more steps on that multiplier
// (divide by 100, sum, divide by 7, remainder) in S_WQ, S_WSUM, S_W7 and S_WMOD.
// A rejected set skips the walk. Reset loads 1 January 1970 and idles. The receiver cannot
// stall: rsp_strobe is high for a single cycle and the payload holds until the next result.
//
module calendar_date_counter #(
   parameter int MAX_YEAR = 9999
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_cmd,
   input  logic [13:0]        req_year,
   input  logic [3:0]         req_month,
   input  logic signed [15:0] req_amount,
   output logic               rsp_strobe,
   output logic [13:0]        rsp_cur_year,
   output logic [3:0]         rsp_cur_month,
   output logic [4:0]         rsp_cur_day,
   output logic [2:0]         rsp_weekday,
   output logic [8:0]         rsp_year_day,
   output logic               rsp_leap,
   output logic [1:0]         rsp_status
);
   import cdc_pkg::*;

   localparam logic [13:0] MaxYear = 14'(MAX_YEAR);

   // Sequencer state.
   state_type state_ff, state_in;

   // Working date during the month walk. The day is signed and may lie far
   // outside the month until the walk has brought it home.
   logic [13:0]        wy_ff, wy_in;
   logic [3:0]         wm_ff, wm_in;
   logic signed [16:0] wd_ff, wd_in;
   logic               wleap_ff, wleap_in;

   // Stored date and its leap flag.
   logic [13:0] date_year_ff, date_year_in;
   logic [3:0]  date_month_ff, date_month_in;
   logic [4:0]  date_day_ff, date_day_in;
   logic        date_leap_ff, date_leap_in;

   logic [1:0]  status_ff, status_in;

   // Weekday working registers: the Zeller year and the running sum.
   logic [13:0] wk_year_ff, wk_year_in;
   logic [14:0] sum_ff, sum_in;

   // Result registers.
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [13:0] rsp_cur_year_ff, rsp_cur_year_in;
   logic [3:0]  rsp_cur_month_ff, rsp_cur_month_in;
   logic [4:0]  rsp_cur_day_ff, rsp_cur_day_in;
   logic [2:0]  rsp_weekday_ff, rsp_weekday_in;
   logic [8:0]  rsp_year_day_ff, rsp_year_day_in;
   logic        rsp_leap_ff, rsp_leap_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // Shared multiplier.
   logic [14:0] mul_a;
   mul_sel_type mul_sel;
   logic [30:0] mul_prod;

   // Combinational helpers.
   logic [4:0]         dim;
   logic [3:0]         prev_m;
   logic [4:0]         prev_dim;
   logic signed [16:0] step_n;
   logic [7:0]         q100;
   logic [14:0]        q100_x100;
   logic [11:0]        q7;
   logic [14:0]        q7_x7;
   logic [14:0]        rem7;
   logic [13:0]        wk_year_now;

   cdc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .sel   (mul_sel),
      .prod  (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         date_year_ff  <= 14'd1970;
         date_month_ff <= 4'd1;
         date_day_ff   <= 5'd1;
         date_leap_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         date_year_ff  <= date_year_in;
         date_month_ff <= date_month_in;
         date_day_ff   <= date_day_in;
         date_leap_ff  <= date_leap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      wy_ff            <= wy_in;
      wm_ff            <= wm_in;
      wd_ff            <= wd_in;
      wleap_ff         <= wleap_in;
      status_ff        <= status_in;
      wk_year_ff       <= wk_year_in;
      sum_ff           <= sum_in;
      rsp_cur_year_ff  <= rsp_cur_year_in;
      rsp_cur_month_ff <= rsp_cur_month_in;
      rsp_cur_day_ff   <= rsp_cur_day_in;
      rsp_weekday_ff   <= rsp_weekday_in;
      rsp_year_day_ff  <= rsp_year_day_in;
      rsp_leap_ff      <= rsp_leap_in;
      rsp_status_ff    <= rsp_status_in;
   end

   always_comb begin
      // Hold everything unless the current step says otherwise.
      state_in         = state_ff;
      wy_in            = wy_ff;
      wm_in            = wm_ff;
      wd_in            = wd_ff;
      wleap_in         = wleap_ff;
      date_year_in     = date_year_ff;
      date_month_in    = date_month_ff;
      date_day_in      = date_day_ff;
      date_leap_in     = date_leap_ff;
      status_in        = status_ff;
      wk_year_in       = wk_year_ff;
      sum_in           = sum_ff;
      rsp_strobe_in    = 1'b0;
      rsp_cur_year_in  = rsp_cur_year_ff;
      rsp_cur_month_in = rsp_cur_month_ff;
      rsp_cur_day_in   = rsp_cur_day_ff;
      rsp_weekday_in   = rsp_weekday_ff;
      rsp_year_day_in  = rsp_year_day_ff;
      rsp_leap_in      = rsp_leap_ff;
      rsp_status_in    = rsp_status_ff;
      mul_a            = 15'd0;
      mul_sel          = MUL_DIV100;

      // Length of the working month, and of the month before it. The month
      // before only sees February when no year wrap happens, so the current
      // leap flag is the right one for it too.
      dim      = month_days(wm_ff) + {4'd0, (wm_ff == 4'd2) && wleap_ff};
      prev_m   = (wm_ff == 4'd1) ? 4'd12 : wm_ff - 4'd1;
      prev_dim = month_days(prev_m) + {4'd0, (prev_m == 4'd2) && wleap_ff};

      // Quotients from the registered product.
      q100      = mul_prod[26:19];
      q100_x100 = {1'b0, q100, 6'd0} + {2'b0, q100, 5'd0} + {5'b0, q100, 2'd0};
      q7        = mul_prod[29:18];
      q7_x7     = {q7, 3'd0} - {3'd0, q7};
      rem7      = sum_ff - q7_x7;

      // Zeller counts January and February in the year before.
      wk_year_now = (date_month_ff <= 4'd2) ? date_year_ff - 14'd1 : date_year_ff;

      unique case (req_cmd)
         CMD_NEXT: step_n = 17'sd1;
         CMD_PREV: step_n = -17'sd1;
         CMD_ADD:  step_n = {req_amount[15], req_amount};
         default:  step_n = 17'sd0;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = ST_OK;
               wy_in     = date_year_ff;
               wm_in     = date_month_ff;
               wleap_in  = date_leap_ff;
               wd_in     = $signed({12'd0, date_day_ff}) + step_n;
               state_in  = S_WALK;
               if (req_cmd == CMD_SET) begin
                  priority if (req_month == 4'd0 || req_month > 4'd12) begin
                     status_in = ST_BAD_MONTH;
                     state_in  = S_WQ;
                  end else if (req_amount < 16'sd1) begin
                     status_in = ST_BAD_DAY;
                     state_in  = S_WQ;
                  end else if (req_year == 14'd0 || req_year > MaxYear) begin
                     status_in = ST_BAD_YEAR;
                     state_in  = S_WQ;
                  end else begin
                     // A new year needs its leap flag before the walk.
                     wy_in    = req_year;
                     wm_in    = req_month;
                     wd_in    = {req_amount[15], req_amount};
                     state_in = S_LQ;
                  end
               end
            end
         end

         S_LQ: begin
            mul_a    = {1'b0, wy_ff};
            mul_sel  = MUL_DIV100;
            state_in = S_LEAP;
         end

         S_LEAP: begin
            // Divisible by 4, and either not by 100 or also by 400.
            wleap_in = (wy_ff[1:0] == 2'd0)
                       && ((q100_x100 != {1'b0, wy_ff}) || (q100[1:0] == 2'd0));
            state_in = S_WALK;
         end

         S_WALK: begin
            priority if (wd_ff > $signed({12'd0, dim})) begin
               // Past the month's end: move on to the next month.
               if (wm_ff == 4'd12) begin
                  if (wy_ff == MaxYear) begin
                     status_in = ST_BAD_YEAR;
                     state_in  = S_WQ;
                  end else begin
                     wd_in    = wd_ff - $signed({12'd0, dim});
                     wm_in    = 4'd1;
                     wy_in    = wy_ff + 14'd1;
                     state_in = S_LQ;
                  end
               end else begin
                  wd_in = wd_ff - $signed({12'd0, dim});
                  wm_in = wm_ff + 4'd1;
               end
            end else if (wd_ff < 17'sd1) begin
               // Before the first: move back a month and add its length.
               if (wm_ff == 4'd1) begin
                  if (wy_ff == 14'd1) begin
                     status_in = ST_BAD_YEAR;
                     state_in  = S_WQ;
                  end else begin
                     wd_in    = wd_ff + $signed({12'd0, prev_dim});
                     wm_in    = prev_m;
                     wy_in    = wy_ff - 14'd1;
                     state_in = S_LQ;
                  end
               end else begin
                  wd_in = wd_ff + $signed({12'd0, prev_dim});
                  wm_in = prev_m;
               end
            end else begin
               // The day lies within the month: the walk is done.
               date_year_in  = wy_ff;
               date_month_in = wm_ff;
               date_day_in   = wd_ff[4:0];
               date_leap_in  = wleap_ff;
               state_in      = S_WQ;
            end
         end

         S_WQ: begin
            wk_year_in = wk_year_now;
            mul_a      = {1'b0, wk_year_now};
            mul_sel    = MUL_DIV100;
            state_in   = S_WSUM;
         end

         S_WSUM: begin
            sum_in = {1'b0, wk_year_ff} + {3'd0, wk_year_ff[13:2]}
                     - {7'd0, q100} + {9'd0, q100[7:2]}
                     + {9'd0, zeller_term(date_month_ff)} + {10'd0, date_day_ff};
            state_in = S_W7;
         end

         S_W7: begin
            mul_a    = sum_ff;
            mul_sel  = MUL_DIV7;
            state_in = S_WMOD;
         end

         S_WMOD: begin
            rsp_strobe_in    = 1'b1;
            rsp_cur_year_in  = date_year_ff;
            rsp_cur_month_in = date_month_ff;
            rsp_cur_day_in   = date_day_ff;
            rsp_weekday_in   = rem7[2:0];
            rsp_year_day_in  = days_before(date_month_ff) + {4'd0, date_day_ff}
                               + {8'd0, date_leap_ff && (date_month_ff > 4'd2)};
            rsp_leap_in      = date_leap_ff;
            rsp_status_in    = status_ff;
            state_in         = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_cur_year  = rsp_cur_year_ff;
   assign rsp_cur_month = rsp_cur_month_ff;
   assign rsp_cur_day   = rsp_cur_day_ff;
   assign rsp_weekday   = rsp_weekday_ff;
   assign rsp_year_day  = rsp_year_day_ff;
   assign rsp_leap      = rsp_leap_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
